/* hdl/pitch_scale_quantizer_top_defines.svh */
// Assertion macros for the pitch scale quantizer checker.
// No dependencies; include by bare file name.
`ifndef PITCH_SCALE_QUANTIZER_TOP_DEFINES_SVH
`define PITCH_SCALE_QUANTIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pitch scale quantizer check failed");

// Next-cycle implication, disabled while reset is low.
`define PSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pitch scale quantizer check failed");

`endif

/* hdl/psq_pkg.sv */
// Constants, scale tables and note lookup functions for the pitch scale quantizer.
// No dependencies.
package psq_pkg;

	localparam int SCALE_CNT    = 17;
	localparam int MAX_NOTES    = 12;
	localparam int BYPASS_SCALE = 17;

	typedef enum logic [2:0] {
		REG_ROOT_KNOB  = 3'd0,
		REG_SCALE_KNOB = 3'd1,
		REG_OCT_OFS    = 3'd2,
		REG_SEMI_OFS   = 3'd3,
		REG_FINE_OFS   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       found;
		logic [3:0] note;
	} note_hit_t;

	localparam logic [3:0] SCALE_LEN [SCALE_CNT] = '{
		4'd7, 4'd6, 4'd12, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
		4'd7, 4'd9, 4'd7, 4'd7, 4'd7, 4'd5, 4'd7, 4'd7
	};

	// Notes in semitones, ascending; entries past the length are padding.
	localparam logic [3:0] SCALE_TAB [SCALE_CNT][MAX_NOTES] = '{
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd1, 4'd4, 4'd5, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd10, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
	};

	// Highest scale note at or below the given semitone (first note is always 0).
	function automatic logic [3:0] note_lo(input logic [4:0] sc, input logic [3:0] semi);
		logic [3:0] lo;
		lo = 4'd0;
		if (sc < 5'(SCALE_CNT)) begin
			for (int i = 0; i < MAX_NOTES; i++) begin
				if (4'(i) < SCALE_LEN[sc] && SCALE_TAB[sc][i] <= semi)
					lo = SCALE_TAB[sc][i];
			end
		end
		return lo;
	endfunction

	// Lowest scale note above the given semitone, if any.
	function automatic note_hit_t note_hi(input logic [4:0] sc, input logic [3:0] semi);
		note_hit_t hit;
		hit = '0;
		if (sc < 5'(SCALE_CNT)) begin
			for (int i = MAX_NOTES - 1; i >= 0; i--) begin
				if (4'(i) < SCALE_LEN[sc] && SCALE_TAB[sc][i] > semi) begin
					hit.found = 1'b1;
					hit.note  = SCALE_TAB[sc][i];
				end
			end
		end
		return hit;
	endfunction

	// round(x / 6144), half away from zero; result in -5..5.
	function automatic logic signed [3:0] round_half_cv(input logic signed [15:0] x);
		logic [16:0] mag;
		logic [2:0]  cnt;
		mag = x[15] ? 17'(-18'(x)) : 17'(x);
		cnt = 3'd0;
		for (int k = 1; k <= 5; k++) begin
			if (mag >= 17'(k * 6144 - 3072))
				cnt = cnt + 3'd1;
		end
		return x[15] ? -4'(signed'({1'b0, cnt})) : 4'(signed'({1'b0, cnt}));
	endfunction

endpackage

/* hdl/pitch_scale_quantizer_top.sv */
// Pitch scale quantizer, one channel: config registers and a two-stage pipeline.
// Depends on psq_pkg.
//
// Usage:
//   Config: wr_en/wr_index/wr_data write one register per cycle (0 root knob,
//   1 scale knob, 2 octave offset, 3 semitone offset, 4 fine offset). The user
//   writes only while no sample is in flight (not enforced). No read-back.
//   Input: a sample beat is taken on each clock edge with start high and busy
//   low. busy is always low: a new sample may enter every cycle.
//   Output: done pulses for one cycle with pitch_out, root_index and
//   scale_index, after the stage 1 and stage 2 registers. The receiver cannot
//   stall; every result must be taken in the cycle it is shown.
//   Throughput: one sample per cycle. Stage 1 applies the CV rounding, root and
//   scale index sums and the octave/semitone shift; stage 2 splits octave and
//   fraction, looks up the neighboring scale notes and adds root and fine.
//   Reset: arst_n low zeroes config and valid flags, dropping in-flight samples.
module pitch_scale_quantizer_top
	import psq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [9:0]         wr_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] pitch_in,
	input  logic signed [15:0] octave_cv,
	input  logic signed [15:0] semitone_cv,
	input  logic signed [15:0] fine_cv,
	input  logic [14:0]        root_cv,
	input  logic [14:0]        scale_cv,
	output logic               done,
	output logic signed [17:0] pitch_out,
	output logic [4:0]         root_index,
	output logic [4:0]         scale_index
);

	logic [3:0]        root_knob_q;
	logic [4:0]        scale_knob_q;
	logic signed [3:0] octave_q;
	logic signed [3:0] semitone_q;
	logic signed [9:0] fine_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_knob_q  <= '0;
			scale_knob_q <= '0;
			octave_q     <= '0;
			semitone_q   <= '0;
			fine_q       <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_ROOT_KNOB:  root_knob_q  <= wr_data[3:0];
				REG_SCALE_KNOB: scale_knob_q <= wr_data[4:0];
				REG_OCT_OFS:    octave_q     <= signed'(wr_data[3:0]);
				REG_SEMI_OFS:   semitone_q   <= signed'(wr_data[3:0]);
				REG_FINE_OFS:   fine_q       <= signed'(wr_data);
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------- stage 1 ----------------
	logic [18:0]        root_prod;
	logic [19:0]        scale_prod;
	logic [3:0]         root_cnt;
	logic [4:0]         scale_cnt;
	logic [4:0]         root_sum;
	logic [5:0]         scale_sum;
	logic [4:0]         scale_sat;
	logic signed [4:0]  oct_steps;
	logic signed [4:0]  semi_steps;
	logic signed [18:0] shifted;
	logic signed [14:0] fine_sum;

	always_comb begin
		// floor(cv * n / 30720) by counting crossed thresholds
		root_prod  = 19'(root_cv) * 19'd11;
		scale_prod = 20'(scale_cv) * 20'd17;
		root_cnt   = 4'd0;
		scale_cnt  = 5'd0;
		for (int k = 1; k <= 11; k++) begin
			if (root_prod >= 19'(k * 30720))
				root_cnt = root_cnt + 4'd1;
		end
		for (int k = 1; k <= 18; k++) begin
			if (scale_prod >= 20'(k * 30720))
				scale_cnt = scale_cnt + 5'd1;
		end
		root_sum  = 5'(root_knob_q) + 5'(root_cnt);
		scale_sum = 6'(scale_knob_q) + 6'(scale_cnt);
		scale_sat = (scale_sum > 6'(BYPASS_SCALE)) ? 5'(BYPASS_SCALE) : scale_sum[4:0];

		oct_steps  = 5'(octave_q) + 5'(round_half_cv(octave_cv));
		semi_steps = 5'(semitone_q) + 5'(round_half_cv(semitone_cv));
		shifted    = 19'(pitch_in) + 19'(oct_steps) * 19'sd3072
		           + 19'(semi_steps) * 19'sd256;
		fine_sum   = 15'(fine_q) + 15'(fine_cv >>> 2);
	end

	logic               valid_s1;
	logic signed [18:0] shifted_s1;
	logic [4:0]         root_s1;
	logic [4:0]         scale_s1;
	logic signed [14:0] fine_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shifted_s1 <= shifted;
			root_s1    <= root_sum;
			scale_s1   <= scale_sat;
			fine_s1    <= fine_sum;
		end
	end

	// ---------------- stage 2 ----------------
	logic signed [8:0]  kilo;        // floor(v / 1024)
	logic [7:0]         kilo_ofs;    // kilo + 96, always positive
	logic [15:0]        div3_prod;
	logic [6:0]         div3;
	logic [1:0]         rem3;
	logic signed [6:0]  oct;
	logic [11:0]        frac;
	logic [3:0]         lo_note;
	note_hit_t          hi_hit;
	logic [11:0]        d_lo;
	logic [11:0]        d_hi;
	logic [3:0]         best;
	logic signed [9:0]  note_sum;
	logic signed [18:0] quant;
	logic signed [18:0] result;

	always_comb begin
		kilo      = 9'(shifted_s1 >>> 10);
		kilo_ofs  = 8'(kilo + 9'sd96);
		// divide by 3 via reciprocal 171/512, exact for values below 256
		div3_prod = 16'(kilo_ofs) * 16'd171;
		div3      = div3_prod[15:9];
		rem3      = 2'(kilo_ofs - 8'(div3) * 8'd3);
		oct       = signed'(div3) - 7'sd32;
		frac      = {rem3, shifted_s1[9:0]};

		lo_note = note_lo(scale_s1, frac[11:8]);
		hi_hit  = note_hi(scale_s1, frac[11:8]);
		d_lo    = frac - {lo_note, 8'd0};
		d_hi    = {hi_hit.note, 8'd0} - frac;
		// lower note wins on a tie; no wrap past the top note
		best    = (hi_hit.found && d_hi < d_lo) ? hi_hit.note : lo_note;

		note_sum = 10'(oct) * 10'sd12 + 10'(root_s1) + 10'(best);
		if (scale_s1 >= 5'(BYPASS_SCALE))
			quant = shifted_s1;
		else
			quant = 19'({note_sum, 8'd0});
		result = quant + 19'(fine_s1);
	end

	logic               valid_s2;
	logic signed [17:0] pitch_s2;
	logic [4:0]         root_s2;
	logic [4:0]         scale_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pitch_s2 <= result[17:0];
			root_s2  <= root_s1;
			scale_s2 <= scale_s1;
		end
	end

	assign done        = valid_s2;
	assign pitch_out   = pitch_s2;
	assign root_index  = root_s2;
	assign scale_index = scale_s2;

endmodule

/* hdl/psq_checker.sv */
// Port-level checker for the pitch scale quantizer, bound to the top level.
// Depends on pitch_scale_quantizer_top_defines.svh.
`include "pitch_scale_quantizer_top_defines.svh"

module psq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [4:0] root_index,
	input logic [4:0] scale_index
);

	// every accepted beat comes out after the stage 1 and stage 2 registers
	`PSQ_ASSERT_NEXT(a_result_follows, clk, arst_n, start && !busy, ##1 done)
	// no result without a beat taken ahead of both pipeline registers
	`PSQ_ASSERT_IMPL(a_no_invented, clk, arst_n, done, $past(start && !busy, 2))
	// scale index saturates at bypass
	`PSQ_ASSERT_IMPL(a_scale_sat, clk, arst_n, done, scale_index <= 5'd17)
	// root index is knob plus at most eleven semitones
	`PSQ_ASSERT_IMPL(a_root_range, clk, arst_n, done, root_index <= 5'd26)

endmodule

bind pitch_scale_quantizer_top psq_checker u_psq_checker (.*);

/* tb/sv/tb.sv */
// Self-checking testbench for pitch_scale_quantizer_top: directed and random samples
// checked against a behavioral scale quantizer. Depends on psq_pkg and the top level.
module tb
	import psq_pkg::*;
;

	typedef struct {
		logic signed [15:0] pitch;
		logic signed [15:0] oct_cv;
		logic signed [15:0] semi_cv;
		logic signed [15:0] fine_cv;
		logic [14:0]        root_cv;
		logic [14:0]        scale_cv;
	} sample_t;

	typedef struct {
		logic signed [17:0] pitch;
		logic [4:0]         root;
		logic [4:0]         scale;
	} note_t;

	localparam int BYPASS = 17;

	// One bit per semitone present in each scale.
	localparam logic [11:0] NOTE_MASK [17] = '{
		12'h5AD, 12'h4E9, 12'hFFF, 12'h5AD, 12'h6AD, 12'h9AD, 12'h533, 12'h56B, 12'h6D5,
		12'hAB5, 12'hFAD, 12'h5AD, 12'h6B5, 12'h5AD, 12'h295, 12'h5AB, 12'hCAB
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [2:0]         wr_index = REG_ROOT_KNOB;
	logic [9:0]         wr_data = '0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] pitch_in = '0;
	logic signed [15:0] octave_cv = '0;
	logic signed [15:0] semitone_cv = '0;
	logic signed [15:0] fine_cv = '0;
	logic [14:0]        root_cv = '0;
	logic [14:0]        scale_cv = '0;
	logic               done;
	logic signed [17:0] pitch_out;
	logic [4:0]         root_index;
	logic [4:0]         scale_index;

	// Register copies as seen by the predictor
	logic [3:0]        cfg_root = '0;
	logic [4:0]        cfg_scale = '0;
	logic signed [3:0] cfg_oct = '0;
	logic signed [3:0] cfg_semi = '0;
	logic signed [9:0] cfg_fine = '0;

	note_t pending_notes [$];
	note_t want_note;
	bit    gaps_on = 1'b1;
	int    samples_sent = 0;
	int    results_seen = 0;
	int    bypass_seen = 0;
	int    settings_used = 0;
	int    mismatches = 0;

	pitch_scale_quantizer_top u_top (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.start(start), .busy(busy),
		.pitch_in(pitch_in), .octave_cv(octave_cv), .semitone_cv(semitone_cv),
		.fine_cv(fine_cv), .root_cv(root_cv), .scale_cv(scale_cv),
		.done(done), .pitch_out(pitch_out), .root_index(root_index), .scale_index(scale_index)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

	// round(x / 6144), ties away from zero
	function automatic int half_steps(input int x);
		if (x >= 0)
			return (x + 3072) / 6144;
		return -((-x + 3072) / 6144);
	endfunction

	function automatic note_t quantize_pitch(input sample_t s);
		note_t res;
		int root, scale, v, oct, frac, best, best_d, d, q;
		root  = int'(cfg_root) + (int'(s.root_cv) * 11) / 30720;
		scale = int'(cfg_scale) + (int'(s.scale_cv) * 17) / 30720;
		if (scale > BYPASS)
			scale = BYPASS;
		v = int'(s.pitch) + 3072 * (int'(cfg_oct) + half_steps(int'(s.oct_cv)))
			+ 256 * (int'(cfg_semi) + half_steps(int'(s.semi_cv)));
		if (scale == BYPASS) begin
			q = v;
		end else begin
			oct    = (v >= 0) ? v / 3072 : -((-v + 3071) / 3072);
			frac   = v - oct * 3072;
			best   = 0;
			best_d = 32'h7FFF_FFFF;
			// ascending scan with strict compare: ties go to the lower note, no wrap
			for (int n = 0; n < 12; n++) begin
				if (NOTE_MASK[scale][n]) begin
					d = (frac > n * 256) ? frac - n * 256 : n * 256 - frac;
					if (d < best_d) begin
						best_d = d;
						best   = n * 256;
					end
				end
			end
			q = oct * 3072 + root * 256 + best;
		end
		q = q + int'(cfg_fine) + (int'(s.fine_cv) >>> 2);
		res.pitch = 18'(q);
		res.root  = 5'(root);
		res.scale = 5'(scale);
		return res;
	endfunction

	function automatic sample_t mk(input int p, o, s, f, r, k);
		sample_t x;
		x.pitch    = 16'(p);
		x.oct_cv   = 16'(o);
		x.semi_cv  = 16'(s);
		x.fine_cv  = 16'(f);
		x.root_cv  = 15'(r);
		x.scale_cv = 15'(k);
		return x;
	endfunction

	// step: spacing of the interesting boundaries for this field
	function automatic logic signed [15:0] rand_signed(input int step);
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return -16'sd30720;
					1: return 16'sd30720;
					2: return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			2, 3: return 16'(($urandom_range(0, 20) - 10) * step + $urandom_range(0, 2) - 1);
			default: return 16'($urandom_range(0, 61440) - 30720);
		endcase
	endfunction

	function automatic logic [14:0] rand_unsigned();
		case ($urandom_range(0, 7))
			0: return 15'($urandom_range(30721, 32767));
			1: return $urandom_range(0, 1) ? 15'd30720 : 15'd0;
			default: return 15'($urandom_range(0, 30720));
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t x;
		x.pitch    = rand_signed(128);
		x.oct_cv   = rand_signed(3072);
		x.semi_cv  = rand_signed(3072);
		x.fine_cv  = rand_signed(4);
		x.root_cv  = rand_unsigned();
		x.scale_cv = rand_unsigned();
		return x;
	endfunction

	task automatic write_settings(input int root, scale, oct, semi, fine);
		int vals [5];
		cfg_reg_t idx;
		vals = '{root, scale, oct, semi, fine};
		for (int i = 0; i < 5; i++) begin
			idx = cfg_reg_t'(i);
			wr_en    <= 1'b1;
			wr_index <= idx;
			wr_data  <= 10'(vals[i]);
			@(posedge clk);
		end
		wr_en     <= 1'b0;
		cfg_root  = 4'(root);
		cfg_scale = 5'(scale);
		cfg_oct   = 4'(oct);
		cfg_semi  = 4'(semi);
		cfg_fine  = 10'(fine);
		settings_used++;
	endtask

	// start is lowered for a gap and in drain; back-to-back beats keep it high
	task automatic send_sample(input sample_t s);
		note_t exp_note;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pitch_in    <= s.pitch;
		octave_cv   <= s.oct_cv;
		semitone_cv <= s.semi_cv;
		fine_cv     <= s.fine_cv;
		root_cv     <= s.root_cv;
		scale_cv    <= s.scale_cv;
		start       <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		exp_note = quantize_pitch(s);
		pending_notes.push_back(exp_note);
		if (exp_note.scale == 5'(BYPASS))
			bypass_seen++;
		samples_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_notes.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_notes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pitch_out=%0d root_index=%0d scale_index=%0d",
						pitch_out, root_index, scale_index);
			end else begin
				want_note = pending_notes.pop_front();
				results_seen++;
				if (pitch_out !== want_note.pitch || root_index !== want_note.root ||
						scale_index !== want_note.scale) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pitch=%0d root=%0d scale=%0d, got %0d %0d %0d",
							want_note.pitch, want_note.root, want_note.scale,
							pitch_out, root_index, scale_index);
				end
			end
		end
	end

	task automatic test_reset_values();
		send_sample(mk(0, 0, 0, 0, 0, 0));
		send_sample(mk(-30720, -30720, -30720, -30720, 0, 0));
		send_sample(mk(30720, 30720, 30720, 30720, 30720, 30720));
		send_sample(mk(-1, 0, 0, 0, 0, 0));
		send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767));
		send_sample(mk(-32768, -32768, -32768, -32768, 0, 0));
		drain();
	endtask

	task automatic test_cv_rounding();
		write_settings(0, 2, 0, 0, 0);
		send_sample(mk(1000, 3072, 3071, -1, 0, 0));
		send_sample(mk(1000, -3072, -3071, -3, 0, 0));
		send_sample(mk(1000, 3071, 9216, -5, 0, 0));
		send_sample(mk(1000, -3071, -9215, 7, 0, 0));
		send_sample(mk(1000, 9216, -9216, 3, 0, 0));
		send_sample(mk(1000, -9216, 3072, -4, 0, 0));
		drain();
	endtask

	task automatic test_note_snapping();
		write_settings(0, 0, 0, 0, 0);
		send_sample(mk(256, 0, 0, 0, 0, 0));      // midway between two notes
		send_sample(mk(1536, 0, 0, 0, 0, 0));
		send_sample(mk(2816, 0, 0, 0, 0, 0));     // above top note, stays in octave
		send_sample(mk(3071, 0, 0, 0, 0, 0));
		drain();
		write_settings(11, 14, 0, 0, 0);
		send_sample(mk(1408, 0, 0, 0, 0, 0));
		send_sample(mk(-1, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_bypass_and_limits();
		write_settings(5, 17, 1, -1, 100);
		send_sample(mk(12345, 0, 0, 0, 0, 0));
		send_sample(mk(-777, 6144, 0, -9, 30720, 0));
		drain();
		// scale sum past the bypass index saturates
		write_settings(11, 16, 0, 0, 0);
		send_sample(mk(1500, 0, 0, 0, 32767, 30720));
		send_sample(mk(1500, 0, 0, 0, 0, 32767));
		drain();
		// register values beyond their nominal range are used as written
		write_settings(15, 31, -8, 7, -512);
		send_sample(mk(30000, 30000, 30000, -30720, 32767, 0));
		drain();
		write_settings(15, 3, 7, -8, 511);
		send_sample(mk(-30000, 30720, -30720, 30720, 32767, 1000));
		drain();
	endtask

	task automatic test_random_settings();
		int phases;
		phases = 30;
		for (int ph = 0; ph < phases; ph++) begin
			if (ph == 0)
				write_settings(0, 0, -5, -5, -256);
			else if (ph == 1)
				write_settings(11, 17, 5, 5, 256);
			else if ($urandom_range(0, 6) == 0)
				write_settings($urandom_range(0, 15), $urandom_range(0, 31),
					$urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
					$urandom_range(0, 1023) - 512);
			else
				write_settings($urandom_range(0, 11), $urandom_range(0, 17),
					$urandom_range(0, 10) - 5, $urandom_range(0, 10) - 5,
					$urandom_range(0, 512) - 256);
			// the closing phases run without gaps
			gaps_on = (ph < phases - 5) && ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(30, 70)) send_sample(rand_sample());
			drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_cv_rounding();
		test_note_snapping();
		test_bypass_and_limits();
		test_random_settings();
		repeat (10) @(posedge clk);
		$display("Sent %0d samples over %0d register settings; %0d results checked, %0d bypassed.",
			samples_sent, settings_used, results_seen, bypass_seen);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
